[design/piecewise_linear_time_remap_assert.svh]
// Assertion macros for the piecewise linear time remap block.
// Used by the port checker; depends on nothing else.
`ifndef PIECEWISE_LINEAR_TIME_REMAP_ASSERT_SVH
`define PIECEWISE_LINEAR_TIME_REMAP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PLTR_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("pltr check failed");
// Next-cycle implication checked outside reset.
`define PLTR_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("pltr check failed");
`endif

[design/pltr_pkg.sv]
// Package for the piecewise linear time remap block: item types and codes.
// Used by every module of the block; depends on nothing.
package pltr_pkg;
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         point_id;
    logic signed [31:0] source_time;
    logic signed [31:0] target_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] synced_time;
    logic [1:0]         status;
    logic [4:0]         point_count;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture the input item
    logic scan;    // compare the entry at the scan index
    logic step;    // advance scan index
    logic shift;   // move one entry for insert/remove
    logic div_go;  // start divider
    logic div_step;
    logic finish;  // form result
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic div_done;
    logic need_div;
  } dp_sts_t;
endpackage

[design/pltr_ctrl.sv]
// Controller state machine for the piecewise linear time remap block.
// Depends on pltr_pkg.
module pltr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       mode,
  input  pltr_pkg::dp_sts_t sts,
  output pltr_pkg::dp_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;
  state_t state_r, state_nxt;
  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      mode_r <= mode;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (mode_r == pltr_pkg::MODE_QUERY) begin
            state_nxt = S_PREP;
          end else if (mode_r == pltr_pkg::MODE_INSERT
                       || mode_r == pltr_pkg::MODE_REMOVE) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) state_nxt = S_DONE;
      end
      // The bracketing points are held now, so the divide decision is valid.
      S_PREP: begin
        if (sts.need_div) begin
          cmd.div_go = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_DONE;
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[design/pltr_dp.sv]
// Datapath of the piecewise linear time remap block: breakpoint memory,
// scan, shift, serial divider and interpolation multiply. Depends on pltr_pkg.
module pltr_dp #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pltr_pkg::in_item_t in_item,
  input  pltr_pkg::dp_cmd_t  cmd,
  output pltr_pkg::dp_sts_t  sts,
  output logic               res_valid,
  output pltr_pkg::out_item_t res_item
);
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = 32 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);

  // Kind of query result, chosen when the scan stops.
  localparam logic [1:0] KIND_INTERP = 2'd0;  // interpolate between L and L + 1
  localparam logic [1:0] KIND_PASS   = 2'd1;  // empty table, time passes through
  localparam logic [1:0] KIND_TARGET = 2'd2;  // single point or at/past the last

  logic signed [31:0] src_mem [MAX_POINTS];
  logic signed [31:0] tgt_mem [MAX_POINTS];
  logic [7:0]         id_mem  [MAX_POINTS];

  pltr_pkg::in_item_t item_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;     // scan index
  logic [CW-1:0] idx_nxt;
  logic [CW-1:0] pos_r;     // insert/remove position, or scan stop for query
  logic          found_r;
  logic          full_r;    // insert met a full table
  logic [CW-1:0] sh_r;      // shift cursor
  logic signed [31:0] src_rd_r;
  logic [7:0]    id_rd_r;
  logic signed [31:0] srcl_r, srch_r, tgtl_r, tgth_r;
  logic [1:0]    kind_r;
  logic [DW-1:0] rem_r, quo_r;
  logic [32:0]   den_r;
  logic [DCW-1:0] dcnt_r;
  logic signed [FRAC_BITS+34:0] prod_r;

  logic          scan_end;
  logic          ins_full;
  logic          scan_done_w;
  assign scan_end = (idx_r >= count_r);
  assign ins_full = (count_r == CW'(MAX_POINTS));

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // The scan compares against the entry read at the index it moves to, so the
  // entry under the scan index is always one registered read ahead.
  always_ff @(posedge clk) begin
    src_rd_r <= src_mem[IW'(idx_nxt)];
    id_rd_r  <= id_mem[IW'(idx_nxt)];
  end

  // Scan termination per mode.
  always_comb begin
    scan_done_w = 1'b0;
    if (scan_end) begin
      scan_done_w = 1'b1;
    end else if (item_r.mode == pltr_pkg::MODE_INSERT) begin
      scan_done_w = (src_rd_r > item_r.source_time) || ins_full;
    end else if (item_r.mode == pltr_pkg::MODE_REMOVE) begin
      scan_done_w = (id_rd_r == item_r.point_id);
    end else if (item_r.mode == pltr_pkg::MODE_QUERY) begin
      scan_done_w = (src_rd_r > item_r.source_time);
    end else begin
      scan_done_w = 1'b1;
    end
  end
  assign sts.scan_done = scan_done_w;

  logic signed [32:0] span_w, diff_w;
  assign span_w = 33'(srch_r) - 33'(srcl_r);
  assign diff_w = 33'(item_r.source_time) - 33'(srcl_r);
  assign sts.need_div = (kind_r == KIND_INTERP) && (span_w > 0) && (diff_w > 0)
                        && (diff_w < span_w);
  assign sts.div_done = (dcnt_r == '0);

  assign sts.shift_done = (item_r.mode == pltr_pkg::MODE_INSERT)
                          ? (ins_full || sh_r <= pos_r)
                          : (!found_r || sh_r + 1'b1 >= count_r);

  // Query bracketing: L is scan stop minus one (0 if none).
  logic [CW-1:0] lq;
  assign lq = (idx_r == '0) ? '0 : idx_r - 1'b1;

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      item_r  <= in_item;
      found_r <= 1'b0;
      full_r  <= 1'b0;
    end
    if (cmd.scan && sts.scan_done) begin
      pos_r   <= idx_r;
      found_r <= !scan_end;
      full_r  <= ins_full && (item_r.mode == pltr_pkg::MODE_INSERT);
    end
    // Divider start.
    if (cmd.div_go) begin
      rem_r  <= '0;
      quo_r  <= DW'(diff_w) << FRAC_BITS;
      den_r  <= span_w;
      dcnt_r <= DCW'(DW);
    end else if (cmd.div_step && dcnt_r != '0) begin
      if ({rem_r[DW-2:0], quo_r[DW-1]} >= DW'(den_r)) begin
        rem_r <= {rem_r[DW-2:0], quo_r[DW-1]} - DW'(den_r);
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.div_step && sts.div_done) begin
      prod_r <= (FRAC_BITS+35)'(34'(tgth_r) - 34'(tgtl_r))
                * (FRAC_BITS+35)'($signed({1'b0, quo_r[FRAC_BITS:0]}));
    end
  end

  // Bracketing endpoints are captured at the edge that ends the scan.
  always_ff @(posedge clk) begin
    if (cmd.load) kind_r <= KIND_PASS;
    if (cmd.scan && sts.scan_done && item_r.mode == pltr_pkg::MODE_QUERY) begin
      if (count_r == '0) begin
        kind_r <= KIND_PASS;
      end else if (count_r == CW'(1)) begin
        kind_r <= KIND_TARGET;
        tgtl_r <= tgt_mem[0];
      end else if (lq >= count_r - 1'b1) begin
        kind_r <= KIND_TARGET;
        tgtl_r <= tgt_mem[IW'(count_r - 1'b1)];
      end else begin
        kind_r <= KIND_INTERP;
        srcl_r <= src_mem[IW'(lq)];
        srch_r <= src_mem[IW'(lq + 1'b1)];
        tgtl_r <= tgt_mem[IW'(lq)];
        tgth_r <= tgt_mem[IW'(lq + 1'b1)];
      end
    end
  end

  // Table shifting and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.shift && sts.shift_done) begin
      if (item_r.mode == pltr_pkg::MODE_INSERT && !ins_full) count_r <= count_r + 1'b1;
      if (item_r.mode == pltr_pkg::MODE_REMOVE && found_r) count_r <= count_r - 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.scan && sts.scan_done) begin
      sh_r <= (item_r.mode == pltr_pkg::MODE_INSERT) ? count_r : idx_r;
    end
    if (cmd.shift) begin
      if (item_r.mode == pltr_pkg::MODE_INSERT && !ins_full) begin
        if (sh_r > pos_r) begin
          src_mem[IW'(sh_r)] <= src_mem[IW'(sh_r - 1'b1)];
          tgt_mem[IW'(sh_r)] <= tgt_mem[IW'(sh_r - 1'b1)];
          id_mem[IW'(sh_r)]  <= id_mem[IW'(sh_r - 1'b1)];
          sh_r <= sh_r - 1'b1;
        end else begin
          src_mem[IW'(pos_r)] <= item_r.source_time;
          tgt_mem[IW'(pos_r)] <= item_r.target_time;
          id_mem[IW'(pos_r)]  <= item_r.point_id;
        end
      end else if (item_r.mode == pltr_pkg::MODE_REMOVE && found_r
                   && sh_r + 1'b1 < count_r) begin
        src_mem[IW'(sh_r)] <= src_mem[IW'(sh_r + 1'b1)];
        tgt_mem[IW'(sh_r)] <= tgt_mem[IW'(sh_r + 1'b1)];
        id_mem[IW'(sh_r)]  <= id_mem[IW'(sh_r + 1'b1)];
        sh_r <= sh_r + 1'b1;
      end
    end
  end

  // Result formation; floor of product toward minus infinity is an arithmetic shift.
  logic signed [31:0] synced_w;
  always_comb begin
    synced_w = 32'sd0;
    if (item_r.mode == pltr_pkg::MODE_QUERY) begin
      unique case (kind_r)
        KIND_PASS:   synced_w = item_r.source_time;
        KIND_TARGET: synced_w = tgtl_r;
        KIND_INTERP: begin
          if (!sts.need_div) begin
            synced_w = (span_w > 0 && diff_w >= span_w && diff_w > 0) ? tgth_r : tgtl_r;
          end else begin
            synced_w = 32'(tgtl_r + 32'(prod_r >>> FRAC_BITS));
          end
        end
        default: synced_w = tgtl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      res_item.synced_time <= synced_w;
      res_item.status <= full_r
                         ? pltr_pkg::ST_FULL
                         : (item_r.mode == pltr_pkg::MODE_REMOVE && !found_r)
                           ? pltr_pkg::ST_NOTFOUND : pltr_pkg::ST_OK;
      res_item.point_count <= 5'(count_r);
    end
  end
endmodule

[design/piecewise_linear_time_remap.sv]
// Top level of the piecewise linear time remap block.
// Depends on pltr_pkg, pltr_ctrl and pltr_dp.
//
//   channel   ports                    handshake
//   input     in_item                  start high while busy low
//   result    out_item                 out_valid for one cycle
//
// An item passes through the accepting state, a scan that steps over the table
// entries one at a time, and a final state. Insert and remove add a shift
// phase that moves one entry at a time. A query adds a setup state and, when
// it interpolates, a serial divide and a multiply state. out_valid is high in
// the cycle after the final state, when a new item may already be accepted.
// Reset empties the table at once.
// Results cannot be stalled by the receiver.
module piecewise_linear_time_remap #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pltr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pltr_pkg::out_item_t out_item
);
  pltr_pkg::dp_cmd_t cmd;
  pltr_pkg::dp_sts_t sts;

  // The controller sequences scan, shift, divide and result.
  pltr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .mode(in_item.mode), .sts(sts), .cmd(cmd)
  );

  // The datapath holds the sorted breakpoint table and the arithmetic.
  pltr_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
    .res_valid(out_valid), .res_item(out_item)
  );
endmodule

[design/pltr_checker.sv]
// Port checker for the piecewise linear time remap block, bound to the top.
// Depends on pltr_pkg and the assertion macro header.
`include "piecewise_linear_time_remap_assert.svh"
module pltr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input pltr_pkg::out_item_t out_item
);
  `PLTR_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PLTR_ASSERT_NXT(a_single_result, clk, rst_n, out_valid, !out_valid)
  `PLTR_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, out_item.point_count <= 5'd16)
  `PLTR_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
    out_item.status != 2'd3)
endmodule

bind piecewise_linear_time_remap pltr_checker u_pltr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
